>>> hdl/assert_macros.svh
// Assertion macros shared by the router RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/srt_pkg.sv
// Types, constants and helper functions of the statement router
`timescale 1ns / 1ps
package srt_pkg;

  localparam int unsigned CNT_OUT_W = 16;

  localparam logic [1:0] DEST_NONE   = 2'd0;
  localparam logic [1:0] DEST_INSERT = 2'd1;
  localparam logic [1:0] DEST_DELETE = 2'd2;
  localparam logic [1:0] DEST_UPDATE = 2'd3;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_DASH = 8'h2D;

  localparam logic [2:0] KW_LEN   = 3'd6;
  localparam logic [2:0] LEN_MAX  = 3'd7;
  localparam logic [2:0] BURST_END = 3'd7;

  typedef enum logic [2:0] {
    MODE_WORD = 3'b001,
    MODE_STMT = 3'b010,
    MODE_CMNT = 3'b100
  } mode_e;

  // one queued job: a single result, or a keyword burst of eight
  typedef struct packed {
    logic [1:0]           dest;
    logic [7:0]           data;
    logic                 burst;
    logic [CNT_OUT_W-1:0] ins_cnt;
    logic [CNT_OUT_W-1:0] del_cnt;
    logic [CNT_OUT_W-1:0] upd_cnt;
    logic [CNT_OUT_W-1:0] cmt_cnt;
  } job_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61:8'h7A]}) r = c - 8'h20;
    return r;
  endfunction

  // keyword character at position pos (0..5) for a statement kind
  function automatic logic [7:0] kw_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (kind)
      DEST_INSERT: begin
        case (pos)
          3'd0: r = "I";
          3'd1: r = "N";
          3'd2: r = "S";
          3'd3: r = "E";
          3'd4: r = "R";
          3'd5: r = "T";
          default: r = 8'h00;
        endcase
      end
      DEST_DELETE: begin
        case (pos)
          3'd0: r = "D";
          3'd1: r = "E";
          3'd2: r = "L";
          3'd3: r = "E";
          3'd4: r = "T";
          3'd5: r = "E";
          default: r = 8'h00;
        endcase
      end
      DEST_UPDATE: begin
        case (pos)
          3'd0: r = "U";
          3'd1: r = "P";
          3'd2: r = "D";
          3'd3: r = "A";
          3'd4: r = "T";
          3'd5: r = "E";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/srt_front.sv
// Front end: word scanner, keyword and comment classifier, statement counters
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srt_front
  import srt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       wr_o,
  output job_t       job_o
);

  mode_e                  mode_q, mode_d;
  logic [1:0]             kind_q, kind_d;
  logic [2:0]             len_q, len_d;
  logic                   ins_m_q, ins_m_d;
  logic                   del_m_q, del_m_d;
  logic                   upd_m_q, upd_m_d;
  logic                   dash_q, dash_d;
  logic [COUNT_WIDTH-1:0] ins_q, ins_d;
  logic [COUNT_WIDTH-1:0] del_q, del_d;
  logic [COUNT_WIDTH-1:0] upd_q, upd_d;
  logic [COUNT_WIDTH-1:0] cmt_q, cmt_d;
  logic [7:0]             up_c;
  logic [1:0]             hit;

  assign up_c = to_upper(byte_i);
  assign wr_o = accept_i;

  always_comb begin
    mode_d  = mode_q;
    kind_d  = kind_q;
    len_d   = len_q;
    ins_m_d = ins_m_q;
    del_m_d = del_m_q;
    upd_m_d = upd_m_q;
    dash_d  = dash_q;
    ins_d   = ins_q;
    del_d   = del_q;
    upd_d   = upd_q;
    cmt_d   = cmt_q;
    hit     = DEST_NONE;
    job_o   = '0;

    case (mode_q)
      MODE_STMT: begin
        if (byte_i == CH_SEMI) mode_d = MODE_WORD;
        job_o.dest = kind_q;
        job_o.data = byte_i;
      end
      MODE_CMNT: begin
        if (byte_i == CH_LF) mode_d = MODE_WORD;
      end
      default: begin
        if (!is_space(byte_i)) begin
          if (len_q < KW_LEN) begin
            ins_m_d = ins_m_q & (up_c == kw_char(DEST_INSERT, len_q));
            del_m_d = del_m_q & (up_c == kw_char(DEST_DELETE, len_q));
            upd_m_d = upd_m_q & (up_c == kw_char(DEST_UPDATE, len_q));
          end else begin
            ins_m_d = 1'b0;
            del_m_d = 1'b0;
            upd_m_d = 1'b0;
          end
          if (len_q < 3'd2) dash_d = dash_q & (byte_i == CH_DASH);
          if (len_q != LEN_MAX) len_d = len_q + 3'd1;
        end else if (len_q != 3'd0) begin
          if (len_q == KW_LEN) begin
            if (ins_m_q)      hit = DEST_INSERT;
            else if (del_m_q) hit = DEST_DELETE;
            else if (upd_m_q) hit = DEST_UPDATE;
          end
          if (hit != DEST_NONE) begin
            case (hit)
              DEST_INSERT: ins_d = (ins_q == '1) ? ins_q : ins_q + 1'b1;
              DEST_DELETE: del_d = (del_q == '1) ? del_q : del_q + 1'b1;
              default:     upd_d = (upd_q == '1) ? upd_q : upd_q + 1'b1;
            endcase
            kind_d      = hit;
            mode_d      = MODE_STMT;
            job_o.dest  = hit;
            job_o.data  = byte_i;
            job_o.burst = 1'b1;
          end else if (len_q >= 3'd2 && dash_q) begin
            cmt_d = (cmt_q == '1) ? cmt_q : cmt_q + 1'b1;
            if (byte_i != CH_LF) mode_d = MODE_CMNT;
          end
          // any word end clears the word tracking
          len_d   = 3'd0;
          ins_m_d = 1'b1;
          del_m_d = 1'b1;
          upd_m_d = 1'b1;
          dash_d  = 1'b1;
        end
      end
    endcase

    job_o.ins_cnt = CNT_OUT_W'(ins_d);
    job_o.del_cnt = CNT_OUT_W'(del_d);
    job_o.upd_cnt = CNT_OUT_W'(upd_d);
    job_o.cmt_cnt = CNT_OUT_W'(cmt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_WORD;
      kind_q  <= DEST_NONE;
      len_q   <= 3'd0;
      ins_m_q <= 1'b1;
      del_m_q <= 1'b1;
      upd_m_q <= 1'b1;
      dash_q  <= 1'b1;
      ins_q   <= '0;
      del_q   <= '0;
      upd_q   <= '0;
      cmt_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      ins_m_q <= ins_m_d;
      del_m_q <= del_m_d;
      upd_m_q <= upd_m_d;
      dash_q  <= dash_d;
      ins_q   <= ins_d;
      del_q   <= del_d;
      upd_q   <= upd_d;
      cmt_q   <= cmt_d;
    end
  end

  `ASSERT_IMPL(a_stmt_kind, mode_q == MODE_STMT, kind_q != DEST_NONE)
  `ASSERT_IMPL(a_word_len, mode_q != MODE_WORD, len_q == 3'd0)
  `ASSERT_IMPL(a_burst_dest, wr_o && job_o.burst, job_o.dest != DEST_NONE)

endmodule

>>> hdl/srt_fifo.sv
// Short job queue between the classifier and the result expander
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srt_fifo
  import srt_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_job_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output job_t rd_job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o   = (cnt_q == CNT_FULL);
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      if (do_wr && !do_rd)      cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_FULL)
  `ASSERT_NEXT(a_fill, do_wr && !do_rd, !empty_o)

endmodule

>>> hdl/srt_back.sv
// Back end: expands queued jobs into result items behind an output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srt_back
  import srt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  job_t                 q_job_i,
  output logic                 q_rd_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [1:0]           dest_o,
  output logic [7:0]           data_o,
  output logic                 last_o,
  output logic [CNT_OUT_W-1:0] insert_count_o,
  output logic [CNT_OUT_W-1:0] delete_count_o,
  output logic [CNT_OUT_W-1:0] update_count_o,
  output logic [CNT_OUT_W-1:0] comment_count_o
);

  job_t       job_q;
  logic       vld_q;
  logic [2:0] idx_q;
  logic       take;

  assign empty_o = !vld_q;
  assign last_o  = !job_q.burst || (idx_q == BURST_END);
  assign take    = !vld_q || (pop_i && last_o);
  assign q_rd_o  = take && !q_empty_i;

  assign dest_o          = job_q.dest;
  assign insert_count_o  = job_q.ins_cnt;
  assign delete_count_o  = job_q.del_cnt;
  assign update_count_o  = job_q.upd_cnt;
  assign comment_count_o = job_q.cmt_cnt;

  // burst: newline, six keyword letters, then the delimiter
  always_comb begin
    data_o = job_q.data;
    if (job_q.burst) begin
      if (idx_q == 3'd0)           data_o = CH_LF;
      else if (idx_q != BURST_END) data_o = kw_char(job_q.dest, idx_q - 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) job_q <= q_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 3'd0;
    end else if (q_rd_o) begin
      vld_q <= 1'b1;
      idx_q <= 3'd0;
    end else if (vld_q && pop_i) begin
      if (last_o) begin
        vld_q <= 1'b0;
        idx_q <= 3'd0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  `ASSERT_IMPL(a_idx_burst, idx_q != 3'd0, vld_q && job_q.burst)
  `ASSERT_NEXT(a_drain, vld_q && pop_i && last_o && q_empty_i, !vld_q)
  `ASSERT_NEXT(a_step, vld_q && pop_i && !last_o, vld_q && idx_q == $past(idx_q) + 3'd1)

endmodule

>>> hdl/sql_statement_router.sv
// Top level of the statement router: classifier, job queue and result expander
`timescale 1ns / 1ps
// Takes one text byte per cycle while full is low and gives one result per byte, or eight
// for a byte that ends an INSERT, DELETE or UPDATE word (newline, keyword, delimiter).
// The classifier handles a byte in the cycle it is accepted and queues it; the result side
// loads it into its output register once that register is free, and single-result items flow at
// one per cycle while pop stays high. A keyword burst holds the output until its eight results
// are popped. The job queue (FIFO_DEPTH entries) lets bytes keep arriving during a burst until
// it fills. Counters are COUNT_WIDTH bits, saturating; the count ports show their low 16 bits.
module sql_statement_router
  import srt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned FIFO_DEPTH  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           text_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           dest_o,
  output logic [7:0]           data_o,
  output logic                 last_o,
  output logic [CNT_OUT_W-1:0] insert_count_o,
  output logic [CNT_OUT_W-1:0] delete_count_o,
  output logic [CNT_OUT_W-1:0] update_count_o,
  output logic [CNT_OUT_W-1:0] comment_count_o
);

  logic accept;
  logic q_wr, q_rd, q_empty;
  job_t wr_job, rd_job;

  assign accept = push && !full;

  srt_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (text_byte_i),
    .wr_o     (q_wr),
    .job_o    (wr_job)
  );

  srt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_job_i (wr_job),
    .full_o   (full),
    .rd_i     (q_rd),
    .empty_o  (q_empty),
    .rd_job_o (rd_job)
  );

  srt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_job_i         (rd_job),
    .q_rd_o          (q_rd),
    .empty_o         (empty),
    .pop_i           (pop),
    .dest_o          (dest_o),
    .data_o          (data_o),
    .last_o          (last_o),
    .insert_count_o  (insert_count_o),
    .delete_count_o  (delete_count_o),
    .update_count_o  (update_count_o),
    .comment_count_o (comment_count_o)
  );

endmodule

>>> tb/sql_statement_router_test.sv
// Testbench of the statement router: byte stream driver, result predictor and checker
`timescale 1ns / 1ps
module sql_statement_router_test;
  import srt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef struct packed {
    logic [1:0]           dest;
    logic [7:0]           data;
    logic                 last;
    logic [CNT_OUT_W-1:0] ins;
    logic [CNT_OUT_W-1:0] del;
    logic [CNT_OUT_W-1:0] upd;
    logic [CNT_OUT_W-1:0] cmt;
  } routed_t;

  typedef struct packed {
    logic [7:0] text;
    logic       drain_first;  // hold this item back until all results are in
  } text_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 pop = 1'b0;
  logic [7:0]           text_byte = 8'h00;
  logic                 full;
  logic                 empty;
  logic [1:0]           rx_dest;
  logic [7:0]           rx_data;
  logic                 rx_last;
  logic [CNT_OUT_W-1:0] rx_ins;
  logic [CNT_OUT_W-1:0] rx_del;
  logic [CNT_OUT_W-1:0] rx_upd;
  logic [CNT_OUT_W-1:0] rx_cmt;

  text_item_t  pending_bytes[$];
  routed_t     expected_routes[$];
  logic        hold_next = 1'b0;
  int unsigned cycles = 0;
  int unsigned fail_count = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned send_pct = 0;
  int unsigned take_pct = 0;
  logic        send_now;
  logic        take_now;

  // router state as the predictor sees it
  mode_e                scan_mode = MODE_WORD;
  logic [1:0]           stmt_kind = DEST_NONE;
  logic [2:0]           word_len = 3'd0;
  logic                 ins_ok = 1'b1;
  logic                 del_ok = 1'b1;
  logic                 upd_ok = 1'b1;
  logic                 dash_ok = 1'b1;
  logic [CNT_OUT_W-1:0] ins_total = '0;
  logic [CNT_OUT_W-1:0] del_total = '0;
  logic [CNT_OUT_W-1:0] upd_total = '0;
  logic [CNT_OUT_W-1:0] cmt_total = '0;

  sql_statement_router u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .text_byte_i     (text_byte),
    .empty           (empty),
    .pop             (pop),
    .dest_o          (rx_dest),
    .data_o          (rx_data),
    .last_o          (rx_last),
    .insert_count_o  (rx_ins),
    .delete_count_o  (rx_del),
    .update_count_o  (rx_upd),
    .comment_count_o (rx_cmt)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] keyword_byte(logic [1:0] k, int pos);
    logic [47:0] w;
    case (k)
      DEST_INSERT: w = "INSERT";
      DEST_DELETE: w = "DELETE";
      default:     w = "UPDATE";
    endcase
    return w[47-8*pos -: 8];
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [CNT_OUT_W-1:0] sat_bump(logic [CNT_OUT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [7:0] blank_byte();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SP : CH_TAB + r[7:0];
  endfunction

  task automatic add_route(logic [1:0] dest, logic [7:0] data, logic last);
    expected_routes.push_back('{dest, data, last, ins_total, del_total, upd_total, cmt_total});
  endtask

  task automatic clear_word();
    word_len = 3'd0;
    ins_ok = 1'b1;
    del_ok = 1'b1;
    upd_ok = 1'b1;
    dash_ok = 1'b1;
  endtask

  // works out the results of one accepted byte and moves the state on
  task automatic route_byte(logic [7:0] c);
    logic [7:0] u;
    logic [1:0] k;
    u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
    k = DEST_NONE;
    case (scan_mode)
      MODE_STMT: begin
        if (c == CH_SEMI) scan_mode = MODE_WORD;
        add_route(stmt_kind, c, 1'b1);
      end
      MODE_CMNT: begin
        if (c == CH_LF) scan_mode = MODE_WORD;
        add_route(DEST_NONE, 8'h00, 1'b1);
      end
      default: begin
        if (!is_blank(c)) begin
          if (word_len < 3'd6) begin
            ins_ok &= (u == keyword_byte(DEST_INSERT, word_len));
            del_ok &= (u == keyword_byte(DEST_DELETE, word_len));
            upd_ok &= (u == keyword_byte(DEST_UPDATE, word_len));
          end else begin
            ins_ok = 1'b0;
            del_ok = 1'b0;
            upd_ok = 1'b0;
          end
          if (word_len < 3'd2) dash_ok &= (c == CH_DASH);
          if (word_len < 3'd7) word_len++;
          add_route(DEST_NONE, 8'h00, 1'b1);
        end else if (word_len == 3'd0) begin
          add_route(DEST_NONE, 8'h00, 1'b1);
        end else begin
          if (word_len == 3'd6) begin
            if (ins_ok) k = DEST_INSERT;
            else if (del_ok) k = DEST_DELETE;
            else if (upd_ok) k = DEST_UPDATE;
          end
          if (k != DEST_NONE) begin
            case (k)
              DEST_INSERT: ins_total = sat_bump(ins_total);
              DEST_DELETE: del_total = sat_bump(del_total);
              default:     upd_total = sat_bump(upd_total);
            endcase
            stmt_kind = k;
            scan_mode = MODE_STMT;
            clear_word();
            add_route(k, CH_LF, 1'b0);
            for (int i = 0; i < 6; i++) add_route(k, keyword_byte(k, i), 1'b0);
            add_route(k, c, 1'b1);
          end else begin
            if (word_len >= 3'd2 && dash_ok) begin
              cmt_total = sat_bump(cmt_total);
              if (c != CH_LF) scan_mode = MODE_CMNT;
            end
            clear_word();
            add_route(DEST_NONE, 8'h00, 1'b1);
          end
        end
      end
    endcase
  endtask

  task automatic add_byte(logic [7:0] b);
    pending_bytes.push_back('{b, hold_next});
    hold_next = 1'b0;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // driver: acceptance and prediction at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      route_byte(text_byte);
      pending_bytes.delete(0);
    end
  end

  // driver: next item offered at the falling edge
  always @(negedge clk_i) begin
    if (cycles % 128 == 0) send_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    send_now = rst_ni && pending_bytes.size() != 0;
    if (send_now && pending_bytes[0].drain_first && expected_routes.size() != 0)
      send_now = 1'b0;
    if (send_gap != 0) begin
      send_gap--;
      send_now = 1'b0;
    end else if (send_now && pending_bytes.size() > 40 && $urandom_range(0, 99) < send_pct) begin
      send_gap = $urandom_range(0, 15);
      send_now = 1'b0;
    end
    push <= send_now;
    if (send_now) text_byte <= pending_bytes[0].text;
  end

  // driver: result side stalls
  always @(negedge clk_i) begin
    if (cycles % 128 == 64) take_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    take_now = rst_ni;
    if (take_gap != 0) begin
      take_gap--;
      take_now = 1'b0;
    end else if (take_now && pending_bytes.size() > 40 && $urandom_range(0, 99) < take_pct) begin
      take_gap = $urandom_range(0, 15);
      take_now = 1'b0;
    end
    pop <= take_now;
  end

  // monitor: check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_routes.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: dest %0d data %02h last %0b", rx_dest, rx_data, rx_last);
        fail_count++;
      end else if (rx_dest !== expected_routes[0].dest || rx_data !== expected_routes[0].data ||
                   rx_last !== expected_routes[0].last || rx_ins !== expected_routes[0].ins ||
                   rx_del !== expected_routes[0].del || rx_upd !== expected_routes[0].upd ||
                   rx_cmt !== expected_routes[0].cmt) begin
        if (fail_count < 10)
          $display("mismatch: want dest %0d data %02h last %0b cnt %0d/%0d/%0d/%0d,",
                   expected_routes[0].dest, expected_routes[0].data, expected_routes[0].last,
                   expected_routes[0].ins, expected_routes[0].del, expected_routes[0].upd,
                   expected_routes[0].cmt,
                   " got dest %0d data %02h last %0b cnt %0d/%0d/%0d/%0d",
                   rx_dest, rx_data, rx_last, rx_ins, rx_del, rx_upd, rx_cmt);
        fail_count++;
        expected_routes.delete(0);
      end else begin
        expected_routes.delete(0);
      end
    end
  end

  initial begin
    int unsigned directed_len;
    int unsigned n;
    logic [1:0]  k;
    logic [7:0]  b;

    // comment word cut short by LF, then each statement kind, INSERT in mixed case
    add_text("--\n");
    add_text("InSeRt\v;");
    add_text("delete\t");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(CH_SEMI);
    add_text("UPDATE\r;");
    directed_len = pending_bytes.size();
    hold_next = 1'b1;

    while (pending_bytes.size() < directed_len + RANDOM_ITEMS) begin
      if (pending_bytes.size() >= directed_len + RANDOM_ITEMS / 2 &&
          pending_bytes.size() < directed_len + RANDOM_ITEMS / 2 + 8)
        hold_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin  // statement with random body
          k = 2'($urandom_range(1, 3));
          for (int i = 0; i < 6; i++) begin
            b = keyword_byte(k, i);
            if ($urandom_range(0, 1)) b = b | 8'h20;
            add_byte(b);
          end
          add_byte(blank_byte());
          n = $urandom_range(0, 8);
          for (int i = 0; i < n; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_SEMI);
            add_byte(b);
          end
          add_byte(CH_SEMI);
        end
        4, 5: begin  // comment, either ended at once by LF or with a body
          add_byte(CH_DASH);
          add_byte(CH_DASH);
          n = $urandom_range(0, 6);
          for (int i = 0; i < n; i++) add_byte(8'($urandom_range(8'h21, 8'h7E)));
          if ($urandom_range(0, 1)) begin
            add_byte(CH_LF);
          end else begin
            add_byte(blank_byte());
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
              do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
              add_byte(b);
            end
            add_byte(CH_LF);
          end
        end
        6: begin  // near-miss keyword: cut short, lengthened or one letter off
          k = 2'($urandom_range(1, 3));
          case ($urandom_range(0, 2))
            0: begin
              n = $urandom_range(1, 5);
              for (int i = 0; i < n; i++) add_byte(keyword_byte(k, i));
            end
            1: begin
              for (int i = 0; i < 6; i++) add_byte(keyword_byte(k, i));
              n = $urandom_range(1, 2);
              for (int i = 0; i < n; i++) add_byte(8'($urandom_range("A", "Z")));
            end
            default: begin
              n = $urandom_range(0, 5);
              for (int i = 0; i < 6; i++)
                add_byte(i == n ? keyword_byte(k, i) ^ 8'h01 : keyword_byte(k, i));
            end
          endcase
          add_byte(blank_byte());
        end
        7, 8: begin  // plain word
          n = $urandom_range(1, 9);
          for (int i = 0; i < n; i++) add_byte(8'($urandom_range(8'h21, 8'h7E)));
          add_byte(blank_byte());
        end
        default: begin  // noise
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || expected_routes.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
